### sv/lrts_pkg.sv
package lrts_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int CPU_MAX = 8;
	localparam int TICK_BITS = 32;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CPU_W = 3;
	localparam int CNT_W = SLOT_W + 1;
	localparam int ENTRY_W = 2 + CPU_W + TICK_BITS;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0,
		CMD_TICK = 3'd1,
		CMD_SET_STATE = 3'd2,
		CMD_SELECT = 3'd3,
		CMD_FREE = 3'd4
	} cmd_t;

	localparam logic [1:0] RS_READY = 2'd0;

	typedef struct packed {
		logic [2:0] cmd;
		logic [5:0] slot;
		logic [1:0] run_state;
		logic [2:0] cpu_id;
		logic [5:0] current_slot;
	} req_t;

	typedef struct packed {
		logic [5:0] result_slot;
		logic found;
	} rsp_t;

	// one table entry as held in memory
	typedef struct packed {
		logic [1:0] run_state;
		logic [CPU_W-1:0] cpu;
		logic [TICK_BITS-1:0] ticks;
	} entry_t;

	// front-to-back queue entry: request plus resolved CPU count
	typedef struct packed {
		req_t req;
		logic [3:0] ncpu;
	} job_t;

endpackage

### sv/lrts_ram.sv
module lrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/lrts_front.sv
module lrts_front import lrts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t cmd_in,
	input logic cfg_we,
	input logic [3:0] cfg_wdata,
	input logic pop,
	output logic busy,
	output logic q_valid,
	output job_t q_head
);

	logic [3:0] cpu_total_q;
	logic [3:0] ncpu;
	job_t queue_q [QUEUE_DEPTH];
	logic [1:0] count_q;
	logic push;

	// clamp the CPU count into its legal range
	always_comb begin
		if (cpu_total_q == 4'd0) begin
			ncpu = 4'd1;
		end else if (cpu_total_q > 4'(CPU_MAX)) begin
			ncpu = 4'(CPU_MAX);
		end else begin
			ncpu = cpu_total_q;
		end
	end

	assign busy = (count_q == 2'(QUEUE_DEPTH));
	assign push = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_head = queue_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_total_q <= 4'd1;
		end else if (cfg_we) begin
			cpu_total_q <= cfg_wdata;
		end
	end

	// advance the shift queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			queue_q[0] <= queue_q[1];
		end
		if (push) begin
			if (count_q == 2'd0 || (count_q == 2'd1 && pop)) begin
				queue_q[0] <= '{req: cmd_in, ncpu: ncpu};
			end else begin
				queue_q[count_q[0] ^ pop] <= '{req: cmd_in, ncpu: ncpu};
			end
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'(QUEUE_DEPTH) && !pop) |=> busy) else $error("busy dropped");
`endif

endmodule

### sv/lrts_back.sv
module lrts_back import lrts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input job_t q_head,
	output logic pop,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_UPD = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_FIN = 5'b10000
	} state_t;

	state_t state_q;
	job_t job_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [CPU_W-1:0] next_cpu_q;
	logic [CNT_W-1:0] idx_q;
	logic [SLOT_W-1:0] cand_s1;
	logic cand_ok_s1;
	logic have_q;
	logic [TICK_BITS-1:0] best_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic free_found;
	logic [SLOT_W-1:0] free_slot;

	logic we;
	logic [SLOT_W-1:0] waddr, raddr;
	entry_t wdata, rdata;
	logic [CPU_W:0] alloc_cpu;
	logic [CPU_W:0] cpu_inc;

	lrts_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// lowest free slot from the valid bits
	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign alloc_cpu = ({1'b0, next_cpu_q} < q_head.ncpu[CPU_W:0]) ?
		{1'b0, next_cpu_q} : '0;
	assign cpu_inc = alloc_cpu + 1'b1;

	assign pop = (state_q == ST_IDLE) && q_valid;
	// hold the addressed slot on the read port until the update
	assign raddr = (state_q == ST_IDLE) ? q_head.req.slot :
		(state_q == ST_SCAN) ? idx_q[SLOT_W-1:0] : job_q.req.slot;

	// memory writes: allocate from idle, tick and set state from update
	always_comb begin
		we = 1'b0;
		waddr = job_q.req.slot;
		wdata = rdata;
		if (pop && q_head.req.cmd == CMD_ALLOC && free_found) begin
			we = 1'b1;
			waddr = free_slot;
			wdata = '{run_state: RS_READY, cpu: alloc_cpu[CPU_W-1:0], ticks: '0};
		end else if (state_q == ST_UPD && valid_q[job_q.req.slot]) begin
			if (job_q.req.cmd == CMD_TICK) begin
				we = (rdata.ticks != '1);
				wdata.ticks = rdata.ticks + 1'b1;
			end else if (job_q.req.cmd == CMD_SET_STATE) begin
				we = 1'b1;
				wdata.run_state = job_q.req.run_state;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= '0;
			valid_q <= '0;
			next_cpu_q <= '0;
			done <= 1'b0;
			rsp <= '0;
			idx_q <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			best_slot_q <= '0;
			cand_s1 <= '0;
			cand_ok_s1 <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						job_q <= q_head;
						case (q_head.req.cmd)
							CMD_ALLOC: begin
								done <= 1'b1;
								rsp <= '{result_slot: free_found ? free_slot : '0,
									found: free_found};
								if (free_found) begin
									valid_q[free_slot] <= 1'b1;
									next_cpu_q <= (cpu_inc == q_head.ncpu[CPU_W:0]) ?
										'0 : cpu_inc[CPU_W-1:0];
								end
							end
							CMD_FREE: begin
								done <= 1'b1;
								rsp <= '0;
								valid_q[q_head.req.slot] <= 1'b0;
							end
							CMD_TICK, CMD_SET_STATE: state_q <= ST_READ;
							CMD_SELECT: begin
								idx_q <= CNT_W'(q_head.ncpu);
								have_q <= 1'b0;
								cand_ok_s1 <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: begin
								done <= 1'b1;
								rsp <= '0;
							end
						endcase
					end
				end
				ST_READ: state_q <= ST_UPD;
				ST_UPD: begin
					done <= 1'b1;
					rsp <= '0;
					state_q <= ST_IDLE;
				end
				// read one slot a cycle; compare the previous read
				ST_SCAN: begin
					if (cand_ok_s1 && rdata.run_state == job_q.req.run_state &&
						rdata.cpu == job_q.req.cpu_id &&
						(!have_q || rdata.ticks < best_q)) begin
						have_q <= 1'b1;
						best_q <= rdata.ticks;
						best_slot_q <= cand_s1;
					end
					cand_s1 <= idx_q[SLOT_W-1:0];
					cand_ok_s1 <= (idx_q < CNT_W'(SLOT_COUNT)) &&
						valid_q[idx_q[SLOT_W-1:0]] &&
						(idx_q[SLOT_W-1:0] != job_q.req.current_slot);
					if (idx_q >= CNT_W'(SLOT_COUNT)) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
					if (have_q) begin
						rsp <= '{result_slot: best_slot_q, found: 1'b1};
					end else if (job_q.req.run_state == RS_READY &&
						{1'b0, job_q.req.cpu_id} < job_q.ncpu) begin
						rsp <= '{result_slot: SLOT_W'(job_q.req.cpu_id), found: 1'b1};
					end else begin
						rsp <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done || $past(pop)) else $error("repeated result");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE) else $error("pop while working");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> done) else $error("select lost result");
	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, next_cpu_q} < 4'(CPU_MAX)) else $error("cpu pointer out of range");
`endif

endmodule

### sv/least_run_time_task_selector.sv
// Task table of 64 slots with least-run-time select. Issue a transaction by
// raising start while busy is low; a short queue takes up to two commands
// ahead of the executor. Each command gives exactly one result, shown on rsp
// for one cycle with done high; it cannot be held off. Allocate and free
// finish from idle, tick and set state do a read-modify-write of the slot
// memory, and select is set by the scan that reads one slot per cycle from
// the table memory, starting past the CPU slots (shorter with more CPUs).
// Write cpu_total only when idle.
module least_run_time_task_selector import lrts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t cmd_in,
	output logic busy,
	input logic cfg_we,
	input logic [3:0] cfg_wdata,
	output logic done,
	output rsp_t rsp
);

	logic pop;
	logic q_valid;
	job_t q_head;

	lrts_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd_in(cmd_in),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .pop(pop),
		.busy(busy), .q_valid(q_valid), .q_head(q_head)
	);

	lrts_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head),
		.pop(pop), .done(done), .rsp(rsp)
	);

endmodule

### bench/lrts_checker.sv
`timescale 1ns / 100ps

// Watches the command and result channels, predicts each result from a
// private copy of the task table, and counts mismatches.
module lrts_checker import lrts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t cmd_in,
	input logic busy,
	input logic cfg_we,
	input logic [3:0] cfg_wdata,
	input logic done,
	input rsp_t rsp,
	output int fail_count,
	output int pending_count,
	output int result_count
);

	logic [3:0] cpu_total_q;
	logic slot_live [SLOT_COUNT];
	logic [1:0] slot_state [SLOT_COUNT];
	logic [2:0] slot_owner [SLOT_COUNT];
	logic [TICK_BITS-1:0] slot_tick [SLOT_COUNT];
	logic [2:0] rr_cpu;
	rsp_t expected_rsp_q [$];

	// effective CPU count after clamping the register
	function automatic int cpus_active();
		if (cpu_total_q == 0) return 1;
		if (cpu_total_q > CPU_MAX) return CPU_MAX;
		return cpu_total_q;
	endfunction

	// apply one command to the table copy and return its result
	function automatic rsp_t run_command(req_t r);
		rsp_t o;
		int ncpu;
		int c;
		bit have;
		logic [TICK_BITS-1:0] best;
		o = '0;
		ncpu = cpus_active();
		have = 0;
		best = '0;
		case (r.cmd)
			CMD_ALLOC: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (!slot_live[i]) begin
						c = (rr_cpu < ncpu) ? rr_cpu : 0;
						slot_live[i] = 1;
						slot_state[i] = RS_READY;
						slot_tick[i] = '0;
						slot_owner[i] = 3'(c);
						rr_cpu = 3'((c + 1) % ncpu);
						o.result_slot = 6'(i);
						o.found = 1;
						break;
					end
				end
			end
			CMD_TICK: begin
				if (slot_live[r.slot] && slot_tick[r.slot] != '1)
					slot_tick[r.slot] = slot_tick[r.slot] + 1'b1;
			end
			CMD_SET_STATE: begin
				if (slot_live[r.slot]) slot_state[r.slot] = r.run_state;
			end
			CMD_SELECT: begin
				for (int i = ncpu; i < SLOT_COUNT; i++) begin
					if (!slot_live[i] || i == r.current_slot) continue;
					if (slot_state[i] != r.run_state || slot_owner[i] != r.cpu_id) continue;
					if (!have || slot_tick[i] < best) begin
						have = 1;
						best = slot_tick[i];
						o.result_slot = 6'(i);
					end
				end
				if (have) o.found = 1;
				else if (r.run_state == RS_READY && r.cpu_id < ncpu) begin
					o.result_slot = 6'(r.cpu_id);
					o.found = 1;
				end
			end
			CMD_FREE: begin
				if (slot_live[r.slot]) slot_live[r.slot] = 0;
			end
			default: ;
		endcase
		return o;
	endfunction

	// track transactions and compare results on each edge
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			cpu_total_q <= 4'd1;
			rr_cpu = '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_live[i] = 0;
				slot_state[i] = '0;
				slot_owner[i] = '0;
				slot_tick[i] = '0;
			end
			expected_rsp_q.delete();
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (cfg_we) cpu_total_q <= cfg_wdata;
			if (done) begin
				result_count <= result_count + 1;
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: unexpected result slot=%0d found=%0b", $time,
						rsp.result_slot, rsp.found);
					fail_count <= fail_count + 1;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.result_slot !== exp_rsp.result_slot || rsp.found !== exp_rsp.found) begin
						$display("%0t: mismatch expected slot=%0d found=%0b actual slot=%0d found=%0b",
							$time, exp_rsp.result_slot, exp_rsp.found, rsp.result_slot, rsp.found);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) expected_rsp_q.push_back(run_command(cmd_in));
		end
	end

	assign pending_count = expected_rsp_q.size();

endmodule

### bench/tb_least_run_time_task_selector.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the task selector; checking lives in lrts_checker.
module tb_least_run_time_task_selector;
	import lrts_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	req_t cmd_in;
	logic busy;
	logic cfg_we;
	logic [3:0] cfg_wdata;
	logic done;
	rsp_t rsp;
	int fail_count;
	int pending_count;
	int result_count;
	int idle_cycles;
	int sent_count;
	bit calm;

	least_run_time_task_selector dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd_in(cmd_in), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp)
	);

	lrts_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd_in(cmd_in), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// count cycles with no transaction and no result
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// issue one transaction, with an optional random gap before it;
	// start stays high afterwards until the caller idles the bus
	task automatic send(input logic [2:0] c, input logic [5:0] s, input logic [1:0] st,
			input logic [2:0] cpu, input logic [5:0] cur);
		req_t r;
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		r.cmd = c;
		r.slot = s;
		r.run_state = st;
		r.cpu_id = cpu;
		r.current_slot = cur;
		start <= 1;
		cmd_in <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent_count++;
	endtask

	// drop start and wait until every expected result has come
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// drain outstanding results, settle, then write the CPU count
	task automatic set_cpu_total(input logic [3:0] v);
		drain();
		repeat (80) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// mostly well-formed traffic: slots 0 to 15 addressed, selects on random CPU ids
	task automatic random_item();
		int k;
		k = $urandom_range(0, 99);
		if (k < 20) send(CMD_ALLOC, $urandom, $urandom, $urandom, $urandom);
		else if (k < 45) send(CMD_TICK, $urandom_range(0, 15), $urandom, $urandom, $urandom);
		else if (k < 60) send(CMD_SET_STATE, $urandom_range(0, 15), $urandom, $urandom, $urandom);
		else if (k < 70) send(CMD_FREE, $urandom_range(0, 15), $urandom, $urandom, $urandom);
		else if (k < 93) send(CMD_SELECT, $urandom, $urandom, $urandom,
			$urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom);
		else send($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		cmd_in = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		sent_count = 0;
		calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, idle fallback, field extremes
		set_cpu_total(4'd3);
		send(CMD_SELECT, 0, RS_READY, 0, 0);
		send(CMD_SELECT, 0, RS_READY, 7, 63);
		send(CMD_SELECT, 0, 2'd2, 1, 0);
		send(CMD_TICK, 63, 2'd3, 7, 63);
		send(CMD_SET_STATE, 5, 2'd1, 0, 0);
		send(CMD_FREE, 63, 0, 0, 0);
		repeat (6) send(CMD_ALLOC, 0, 0, 0, 0);
		send(CMD_TICK, 3, 0, 0, 0);
		send(CMD_TICK, 3, 0, 0, 0);
		send(CMD_SELECT, 0, RS_READY, 0, 0);
		send(CMD_SELECT, 0, RS_READY, 0, 3);
		send(CMD_SET_STATE, 4, 2'd3, 0, 0);
		send(CMD_SELECT, 0, 2'd3, 1, 0);
		send(CMD_FREE, 1, 0, 0, 0);
		send(CMD_ALLOC, 0, 0, 0, 0);
		send(3'd5, 63, 3, 7, 63);
		send(3'd7, 0, 0, 0, 0);

		// fill the table to show the full case
		set_cpu_total(4'd8);
		repeat (66) send(CMD_ALLOC, 0, 0, 0, 0);
		send(CMD_SELECT, 0, RS_READY, 7, 0);

		// shrinking the count leaves a stale round-robin pointer
		set_cpu_total(4'd2);
		for (int i = 0; i < 64; i++) send(CMD_FREE, i, 0, 0, 0);
		send(CMD_ALLOC, 0, 0, 0, 0);

		// random phases across CPU counts, including out-of-range values
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_cpu_total(4'd1);
				1: set_cpu_total(4'd0);
				2: set_cpu_total(4'd15);
				3: set_cpu_total(4'd9);
				default: set_cpu_total($urandom_range(1, 8));
			endcase
			calm = (ph == 7);
			for (int n = 0; n < 120; n++) begin
				random_item();
				// let the pipeline run empty now and then
				if (n == 60) drain();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		$display("sent %0d commands over CPU counts 0..15, checked %0d results",
			sent_count, result_count);
		if (fail_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

### least_run_time_task_selector.f
sv/lrts_pkg.sv
sv/lrts_ram.sv
sv/lrts_front.sv
sv/lrts_back.sv
sv/least_run_time_task_selector.sv
bench/lrts_checker.sv
bench/tb_least_run_time_task_selector.sv
